FILE: src/usb_control_request_handler_unit_assert.svh
// Assertion macros for the USB control request handler.
`ifndef USB_CONTROL_REQUEST_HANDLER_UNIT_ASSERT_SVH
`define USB_CONTROL_REQUEST_HANDLER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define USBCRH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define USBCRH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define USBCRH_ASSERT(label, prop, msg)
`define USBCRH_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: src/usbcrh_pkg.sv
// Package: codes, constants and types of the USB control request handler.
package usbcrh_pkg;

    localparam int unsigned MAX_STRING_INDEX = 2;
    localparam int unsigned NUM_STRINGS      = 3;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_STALL = 2'd2,
        ACT_ZLP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_SETUP   = 2'd0,
        CMD_OUT_CPL = 2'd1,
        CMD_IN_CPL  = 2'd2,
        CMD_RSVD    = 2'd3
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_LEN  = 3'd0,
        CFG_BOS_LEN     = 3'd1,
        CFG_CONFIG_LEN  = 3'd2,
        CFG_STRING0_LEN = 3'd3,
        CFG_STRING1_LEN = 3'd4,
        CFG_STRING2_LEN = 3'd5,
        CFG_MSOS20_LEN  = 3'd6
    } t_cfg_index;

    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_VENDOR   = 2'd2;

    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] VENDOR_MSOS_CODE      = 8'h01;

    localparam logic [7:0] DT_DEVICE        = 8'd1;
    localparam logic [7:0] DT_CONFIGURATION = 8'd2;
    localparam logic [7:0] DT_STRING        = 8'd3;
    localparam logic [7:0] DT_QUALIFIER     = 8'd6;
    localparam logic [7:0] DT_BOS           = 8'd15;

    localparam logic [2:0] SEL_DEVICE  = 3'd0;
    localparam logic [2:0] SEL_BOS     = 3'd1;
    localparam logic [2:0] SEL_CONFIG  = 3'd2;
    localparam logic [2:0] SEL_STRING0 = 3'd3;

    localparam logic [7:0]  RST_DEVICE_LEN  = 8'd18;
    localparam logic [15:0] RST_BOS_LEN     = 16'd5;
    localparam logic [15:0] RST_CONFIG_LEN  = 16'd9;
    localparam logic [7:0]  RST_STRING0_LEN = 8'd4;
    localparam logic [7:0]  RST_STRING1_LEN = 8'd2;
    localparam logic [7:0]  RST_STRING2_LEN = 8'd2;
    localparam logic [15:0] RST_MSOS20_LEN  = 16'd10;

    localparam logic [7:0] STRING_INDEX_MAX =
        (MAX_STRING_INDEX < NUM_STRINGS - 1) ? 8'(MAX_STRING_INDEX) : 8'(NUM_STRINGS - 1);

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_request;

    function automatic logic [15:0] lesser(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: src/usb_control_request_handler_unit.sv
// Top level: USB endpoint zero control request handler.
//
// Takes one endpoint-zero event per clock (setup, OUT completion, IN completion) when
// ready and gives one result per event: the event is captured in an input register,
// decoded by a single level of compare and select logic (request decode and one 16-bit
// lesser-of compare), and the result lands in an output register together with the
// updated address and configuration state. Throughput is one event per cycle; a stalled
// result holds the pipeline only when both registers are full. The user writes descriptor
// lengths through the configuration channel while no event is in flight; not enforced.
`include "usb_control_request_handler_unit_assert.svh"

module usb_control_request_handler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] request_type, [15:8] request_code, [31:16] request_value,
    // [47:32] request_length
    input  logic [47:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] descriptor_select, [3] vendor_descriptor, [19:4] byte_count,
    // [26:20] device_address, [27] address_enabled, [28] configured, [31:29] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] action
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [usbcrh_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [usbcrh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [7:0]  r_device_len;
    logic [15:0] r_bos_len;
    logic [15:0] r_config_len;
    logic [7:0]  r_string0_len;
    logic [7:0]  r_string1_len;
    logic [7:0]  r_string2_len;
    logic [15:0] r_msos20_len;

    logic                 r_in_valid;
    usbcrh_pkg::t_request r_in;
    logic                 r_out_valid;
    usbcrh_pkg::t_action  r_action;
    logic [2:0]           r_sel;
    logic                 r_vend;
    logic [15:0]          r_count;

    logic [6:0] r_addr;
    logic       r_addr_on;
    logic       r_config_done;

    usbcrh_pkg::t_action n_action;
    logic [2:0]          n_sel;
    logic                n_vend;
    logic [15:0]         n_count;
    logic [6:0]          n_addr;
    logic                n_addr_on;
    logic                n_config_done;

    logic       advance;
    logic [1:0] kind;
    logic [7:0] dtype;
    logic [7:0] idx;
    logic [7:0] slen;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_len  <= usbcrh_pkg::RST_DEVICE_LEN;
            r_bos_len     <= usbcrh_pkg::RST_BOS_LEN;
            r_config_len  <= usbcrh_pkg::RST_CONFIG_LEN;
            r_string0_len <= usbcrh_pkg::RST_STRING0_LEN;
            r_string1_len <= usbcrh_pkg::RST_STRING1_LEN;
            r_string2_len <= usbcrh_pkg::RST_STRING2_LEN;
            r_msos20_len  <= usbcrh_pkg::RST_MSOS20_LEN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                usbcrh_pkg::CFG_DEVICE_LEN:  r_device_len  <= i_cfg_data[7:0];
                usbcrh_pkg::CFG_BOS_LEN:     r_bos_len     <= i_cfg_data;
                usbcrh_pkg::CFG_CONFIG_LEN:  r_config_len  <= i_cfg_data;
                usbcrh_pkg::CFG_STRING0_LEN: r_string0_len <= i_cfg_data[7:0];
                usbcrh_pkg::CFG_STRING1_LEN: r_string1_len <= i_cfg_data[7:0];
                usbcrh_pkg::CFG_STRING2_LEN: r_string2_len <= i_cfg_data[7:0];
                usbcrh_pkg::CFG_MSOS20_LEN:  r_msos20_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.command        <= s_axis_tuser;
            r_in.request_type   <= s_axis_tdata[7:0];
            r_in.request_code   <= s_axis_tdata[15:8];
            r_in.request_value  <= s_axis_tdata[31:16];
            r_in.request_length <= s_axis_tdata[47:32];
        end
    end

    assign kind  = r_in.request_type[6:5];
    assign dtype = r_in.request_value[15:8];
    assign idx   = r_in.request_value[7:0];

    always_comb begin
        case (idx[1:0])
            2'd0:    slen = r_string0_len;
            2'd1:    slen = r_string1_len;
            default: slen = r_string2_len;
        endcase
    end

    always_comb begin
        n_action      = usbcrh_pkg::ACT_NONE;
        n_sel         = usbcrh_pkg::SEL_DEVICE;
        n_vend        = 1'b0;
        n_count       = '0;
        n_addr        = r_addr;
        n_addr_on     = r_addr_on;
        n_config_done = r_config_done;
        case (usbcrh_pkg::t_command'(r_in.command))
            usbcrh_pkg::CMD_SETUP: begin
                if (kind == usbcrh_pkg::KIND_STANDARD) begin
                    if (r_in.request_code == usbcrh_pkg::REQ_GET_DESCRIPTOR) begin
                        if (dtype == usbcrh_pkg::DT_DEVICE) begin
                            n_action = usbcrh_pkg::ACT_SEND;
                            n_sel    = usbcrh_pkg::SEL_DEVICE;
                            n_count  = usbcrh_pkg::lesser({8'd0, r_device_len},
                                                          r_in.request_length);
                        end else if (dtype == usbcrh_pkg::DT_BOS) begin
                            n_action = usbcrh_pkg::ACT_SEND;
                            n_sel    = usbcrh_pkg::SEL_BOS;
                            n_count  = usbcrh_pkg::lesser(r_bos_len, r_in.request_length);
                        end else if (dtype == usbcrh_pkg::DT_CONFIGURATION) begin
                            if (idx == 8'd0) begin
                                n_action = usbcrh_pkg::ACT_SEND;
                                n_sel    = usbcrh_pkg::SEL_CONFIG;
                                n_count  = usbcrh_pkg::lesser(r_config_len,
                                                              r_in.request_length);
                            end else begin
                                n_action = usbcrh_pkg::ACT_STALL;
                            end
                        end else if (dtype == usbcrh_pkg::DT_STRING) begin
                            if (idx <= usbcrh_pkg::STRING_INDEX_MAX) begin
                                n_action = usbcrh_pkg::ACT_SEND;
                                n_sel    = usbcrh_pkg::SEL_STRING0 + {1'b0, idx[1:0]};
                                n_count  = usbcrh_pkg::lesser({8'd0, slen},
                                                              r_in.request_length);
                            end else begin
                                n_action = usbcrh_pkg::ACT_STALL;
                            end
                        end else if (dtype == usbcrh_pkg::DT_QUALIFIER) begin
                            n_action = usbcrh_pkg::ACT_STALL;
                        end
                    end else if (r_in.request_code == usbcrh_pkg::REQ_SET_ADDRESS) begin
                        n_addr    = r_in.request_value[6:0];
                        n_addr_on = 1'b0;
                        n_action  = usbcrh_pkg::ACT_ZLP;
                    end else if (r_in.request_code == usbcrh_pkg::REQ_SET_CONFIGURATION) begin
                        n_config_done = 1'b1;
                        n_action      = usbcrh_pkg::ACT_ZLP;
                    end
                end else if (kind == usbcrh_pkg::KIND_VENDOR) begin
                    if (r_in.request_code == usbcrh_pkg::VENDOR_MSOS_CODE) begin
                        n_action = usbcrh_pkg::ACT_SEND;
                        n_vend   = 1'b1;
                        n_count  = usbcrh_pkg::lesser(r_msos20_len, r_in.request_length);
                    end
                end
            end
            usbcrh_pkg::CMD_IN_CPL: begin
                if (r_addr != 7'd0) begin
                    n_addr_on = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_addr        <= '0;
            r_addr_on     <= 1'b0;
            r_config_done <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_addr        <= n_addr;
                r_addr_on     <= n_addr_on;
                r_config_done <= n_config_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_action <= n_action;
            r_sel    <= n_sel;
            r_vend   <= n_vend;
            r_count  <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_action;
    assign m_axis_tdata  = {3'd0, r_config_done, r_addr_on, r_addr, r_count, r_vend, r_sel};

    `USBCRH_ASSERT(a_idle_fields_zero,
        m_axis_tvalid && m_axis_tuser != usbcrh_pkg::ACT_SEND |-> m_axis_tdata[19:0] == 20'd0,
        "descriptor fields set without send action")
    `USBCRH_ASSERT(a_vendor_sel_zero,
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == 3'd0,
        "vendor descriptor with nonzero select")
    `USBCRH_ASSERT(a_addr_on_nonzero, r_addr_on |-> r_addr != 7'd0,
        "address enabled with zero address")
    `USBCRH_ASSERT_ALWAYS(a_config_sticky,
        i_rst_n && $past(i_rst_n) |-> !$fell(r_config_done),
        "configured flag cleared outside reset")

endmodule

FILE: verif/usb_control_request_handler_unit_tb.sv
// Testbench for the USB endpoint zero request handler: directed table, random events, predictor.
module usb_control_request_handler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import usbcrh_pkg::*;

    localparam logic [7:0] RT_DEV_IN    = 8'h80;
    localparam logic [7:0] RT_VENDOR_IN = 8'hC0;
    localparam logic [7:0] RT_CLASS     = 8'h21;
    localparam logic [7:0] RT_RESERVED  = 8'hE0;
    localparam int         PHASES       = 6;
    localparam int         PHASE_ITEMS  = 200;

    typedef struct packed {
        t_action     action;
        logic [2:0]  sel;
        logic        vend;
        logic [15:0] count;
        logic [6:0]  addr;
        logic        addr_en;
        logic        configured;
    } t_resp;

    typedef struct packed {
        t_request    req;
        bit          known;
        t_action     action;
        logic [2:0]  sel;
        logic        vend;
        logic [15:0] count;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    usb_control_request_handler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of registers and state
    logic [7:0]  dev_len;
    logic [15:0] bos_len;
    logic [15:0] conf_len;
    logic [7:0]  str_len [3];
    logic [15:0] msos_len;
    logic [6:0]  addr_q;
    logic        addr_on_q;
    logic        conf_done_q;

    t_resp pending_resp [$];
    t_row  plan [$];
    int    snd_idle;
    int    rcv_stall;
    int    errors    = 0;
    int    n_sent    = 0;
    int    n_checked = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [15:0] clip(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic void reset_model();
        dev_len     = RST_DEVICE_LEN;
        bos_len     = RST_BOS_LEN;
        conf_len    = RST_CONFIG_LEN;
        str_len[0]  = RST_STRING0_LEN;
        str_len[1]  = RST_STRING1_LEN;
        str_len[2]  = RST_STRING2_LEN;
        msos_len    = RST_MSOS20_LEN;
        addr_q      = '0;
        addr_on_q   = 1'b0;
        conf_done_q = 1'b0;
    endfunction

    function automatic t_resp respond(input t_request r);
        t_resp      o;
        logic [7:0] dtype;
        logic [7:0] idx;
        o     = '0;
        dtype = r.request_value[15:8];
        idx   = r.request_value[7:0];
        if (r.command == CMD_SETUP) begin
            if (r.request_type[6:5] == KIND_STANDARD) begin
                if (r.request_code == REQ_GET_DESCRIPTOR) begin
                    if (dtype == DT_DEVICE) begin
                        o.action = ACT_SEND;
                        o.sel    = SEL_DEVICE;
                        o.count  = clip({8'h00, dev_len}, r.request_length);
                    end else if (dtype == DT_BOS) begin
                        o.action = ACT_SEND;
                        o.sel    = SEL_BOS;
                        o.count  = clip(bos_len, r.request_length);
                    end else if (dtype == DT_CONFIGURATION) begin
                        if (idx == 8'h00) begin
                            o.action = ACT_SEND;
                            o.sel    = SEL_CONFIG;
                            o.count  = clip(conf_len, r.request_length);
                        end else begin
                            o.action = ACT_STALL;
                        end
                    end else if (dtype == DT_STRING) begin
                        if (idx <= STRING_INDEX_MAX) begin
                            o.action = ACT_SEND;
                            o.sel    = SEL_STRING0 + idx[2:0];
                            o.count  = clip({8'h00, str_len[idx[1:0]]}, r.request_length);
                        end else begin
                            o.action = ACT_STALL;
                        end
                    end else if (dtype == DT_QUALIFIER) begin
                        o.action = ACT_STALL;
                    end
                end else if (r.request_code == REQ_SET_ADDRESS) begin
                    addr_q    = r.request_value[6:0];
                    addr_on_q = 1'b0;
                    o.action  = ACT_ZLP;
                end else if (r.request_code == REQ_SET_CONFIGURATION) begin
                    conf_done_q = 1'b1;
                    o.action    = ACT_ZLP;
                end
            end else if (r.request_type[6:5] == KIND_VENDOR) begin
                if (r.request_code == VENDOR_MSOS_CODE) begin
                    o.action = ACT_SEND;
                    o.vend   = 1'b1;
                    o.count  = clip(msos_len, r.request_length);
                end
            end
        end else if (r.command == CMD_IN_CPL) begin
            if (addr_q != '0) addr_on_q = 1'b1;
        end
        o.addr       = addr_q;
        o.addr_en    = addr_on_q;
        o.configured = conf_done_q;
        return o;
    endfunction

    // mix of edge values, short lengths and full-range values
    function automatic logic [15:0] pick_len();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(80));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.command        = CMD_SETUP;
        r.request_type   = 8'($urandom);
        r.request_code   = 8'($urandom);
        r.request_value  = 16'($urandom);
        r.request_length = pick_len();
        pick = $urandom_range(99);
        if (pick < 12) r.command = CMD_IN_CPL;
        else if (pick < 17) r.command = CMD_OUT_CPL;
        else if (pick < 20) r.command = CMD_RSVD;
        pick = $urandom_range(99);
        if (pick < 70) r.request_type[6:5] = KIND_STANDARD;
        else if (pick < 88) r.request_type[6:5] = KIND_VENDOR;
        pick = $urandom_range(99);
        if (r.request_type[6:5] == KIND_VENDOR) begin
            if (pick < 75) r.request_code = VENDOR_MSOS_CODE;
        end else if (pick < 60) begin
            r.request_code = REQ_GET_DESCRIPTOR;
            case ($urandom_range(5))
                0: r.request_value[15:8] = DT_DEVICE;
                1: r.request_value[15:8] = DT_CONFIGURATION;
                2: r.request_value[15:8] = DT_STRING;
                3: r.request_value[15:8] = DT_BOS;
                4: r.request_value[15:8] = DT_QUALIFIER;
                default: ;
            endcase
            if ($urandom_range(3) != 0) r.request_value[7:0] = 8'($urandom_range(3));
        end else if (pick < 75) begin
            r.request_code = REQ_SET_ADDRESS;
            if ($urandom_range(7) == 0) r.request_value[6:0] = '0;
        end else if (pick < 85) begin
            r.request_code = REQ_SET_CONFIGURATION;
        end
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] rtype,
                                    input logic [7:0] rcode, input logic [15:0] value,
                                    input logic [15:0] len, input bit known,
                                    input t_action act, input logic [2:0] sel,
                                    input logic vend, input logic [15:0] cnt);
        t_row row;
        row.req.command        = cmd;
        row.req.request_type   = rtype;
        row.req.request_code   = rcode;
        row.req.request_value  = value;
        row.req.request_length = len;
        row.known  = known;
        row.action = act;
        row.sel    = sel;
        row.vend   = vend;
        row.count  = cnt;
        plan.push_back(row);
    endfunction

    task automatic send_request(input t_request r, input bit known, input t_row row);
        t_resp e;
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.request_length, r.request_value, r.request_code, r.request_type};
        s_axis_tuser  <= r.command;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        e = respond(r);
        if (known) begin
            e.action = row.action;
            e.sel    = row.sel;
            e.vend   = row.vend;
            e.count  = row.count;
        end
        pending_resp.push_back(e);
        n_sent++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DEVICE_LEN:  dev_len    = data[7:0];
            CFG_BOS_LEN:     bos_len    = data;
            CFG_CONFIG_LEN:  conf_len   = data;
            CFG_STRING0_LEN: str_len[0] = data[7:0];
            CFG_STRING1_LEN: str_len[1] = data[7:0];
            CFG_STRING2_LEN: str_len[2] = data[7:0];
            CFG_MSOS20_LEN:  msos_len   = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= rcv_stall);

    always @(posedge i_clk) begin : result_monitor
        t_resp got;
        t_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action     = t_action'(m_axis_tuser);
            got.sel        = m_axis_tdata[2:0];
            got.vend       = m_axis_tdata[3];
            got.count      = m_axis_tdata[19:4];
            got.addr       = m_axis_tdata[26:20];
            got.addr_en    = m_axis_tdata[27];
            got.configured = m_axis_tdata[28];
            n_checked++;
            if (pending_resp.size() == 0) begin
                $error("unexpected result transaction, action %0d", got.action);
                errors++;
            end else begin
                want = pending_resp.pop_front();
                if (got.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, got.action);
                    errors++;
                end
                if (got.sel !== want.sel) begin
                    $error("descriptor_select: expected %0d, got %0d", want.sel, got.sel);
                    errors++;
                end
                if (got.vend !== want.vend) begin
                    $error("vendor_descriptor: expected %0d, got %0d", want.vend, got.vend);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, got.count);
                    errors++;
                end
                if (got.addr !== want.addr) begin
                    $error("device_address: expected %0d, got %0d", want.addr, got.addr);
                    errors++;
                end
                if (got.addr_en !== want.addr_en) begin
                    $error("address_enabled: expected %0d, got %0d",
                           want.addr_en, got.addr_en);
                    errors++;
                end
                if (got.configured !== want.configured) begin
                    $error("configured: expected %0d, got %0d",
                           want.configured, got.configured);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row     none_row;
        t_request r;
        int       n_directed;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        snd_idle      = 0;
        rcv_stall     = 0;
        none_row      = '0;
        reset_model();

        // cmd, bmRequestType, bRequest, wValue, wLength, typed?, action, sel, vendor, count
        add_row(CMD_SETUP, 8'h00, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd64,
                1'b1, ACT_SEND, SEL_DEVICE, 1'b0, 16'd18);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd0,
                1'b1, ACT_SEND, SEL_DEVICE, 1'b0, 16'd0);
        add_row(CMD_SETUP, 8'h9F, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'hFF}, 16'hFFFF,
                1'b1, ACT_SEND, SEL_DEVICE, 1'b0, 16'd18);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_BOS, 8'h00}, 16'hFFFF,
                1'b1, ACT_SEND, SEL_BOS, 1'b0, 16'd5);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_CONFIGURATION, 8'h00},
                16'hFFFF, 1'b1, ACT_SEND, SEL_CONFIG, 1'b0, 16'd9);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_CONFIGURATION, 8'h01},
                16'd64, 1'b1, ACT_STALL, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h00}, 16'd255,
                1'b1, ACT_SEND, SEL_STRING0, 1'b0, 16'd4);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h01}, 16'd1,
                1'b1, ACT_SEND, SEL_STRING0 + 3'd1, 1'b0, 16'd1);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h02}, 16'd64,
                1'b1, ACT_SEND, SEL_STRING0 + 3'd2, 1'b0, 16'd2);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h03}, 16'd64,
                1'b1, ACT_STALL, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'hFF}, 16'd64,
                1'b1, ACT_STALL, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, {DT_QUALIFIER, 8'h00}, 16'd10,
                1'b1, ACT_STALL, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'h0400, 16'd64,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'hFFFF,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_VENDOR_IN, VENDOR_MSOS_CODE, 16'h0007, 16'hFFFF,
                1'b1, ACT_SEND, 3'd0, 1'b1, 16'd10);
        add_row(CMD_SETUP, RT_VENDOR_IN, 8'h02, 16'h0007, 16'd64,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_CLASS, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd64,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, RT_RESERVED, VENDOR_MSOS_CODE, {DT_DEVICE, 8'h00}, 16'd64,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFF7F, 16'd0,
                1'b1, ACT_ZLP, 3'd0, 1'b0, 16'd0);
        add_row(CMD_OUT_CPL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                1'b0, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_IN_CPL, 8'h00, 8'h00, 16'h0000, 16'h0000,
                1'b0, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h0080, 16'd0,
                1'b1, ACT_ZLP, 3'd0, 1'b0, 16'd0);
        add_row(CMD_IN_CPL, 8'h00, 8'h00, 16'h0000, 16'h0000,
                1'b0, ACT_NONE, 3'd0, 1'b0, 16'd0);
        add_row(CMD_SETUP, 8'h00, REQ_SET_CONFIGURATION, 16'hFFFF, 16'hFFFF,
                1'b1, ACT_ZLP, 3'd0, 1'b0, 16'd0);
        add_row(CMD_RSVD, 8'h00, REQ_SET_ADDRESS, 16'h0011, 16'd0,
                1'b1, ACT_NONE, 3'd0, 1'b0, 16'd0);
        n_directed = plan.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_request(plan[k].req, plan[k].known, plan[k]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // phase 0 keeps reset lengths, 1 all zero, 2 all ones, then random
            if (p > 0) begin
                for (int k = 0; k <= int'(CFG_MSOS20_LEN); k++) begin
                    if (p == 1) write_reg(t_cfg_index'(k), 16'h0000);
                    else if (p == 2) write_reg(t_cfg_index'(k), 16'hFFFF);
                    else write_reg(t_cfg_index'(k), pick_len());
                end
                i_cfg_valid <= 1'b0;
            end
            case (p % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 78; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 78; end
                default: begin snd_idle = 24; rcv_stall = 24; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = random_request();
                send_request(r, 1'b0, none_row);
            end
            drain();
        end

        snd_idle  = 0;
        rcv_stall = 0;
        if (pending_resp.size() != 0) begin
            $error("%0d expected results never arrived", pending_resp.size());
        end
        $display("Summary: %0d events sent (%0d from the directed table), %0d results checked",
                 n_sent, n_directed, n_checked);
        $display("Summary: reset, zero, all-ones and random lengths under four idle patterns");
        if (errors == 0 && pending_resp.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
